@@ rtl/qrv_pkg.sv @@
// Package for the quaternion point rotation block: widths, register index
// codes, payload types and the fixed-point constants used by every stage.
// No dependencies.
package qrv_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int QUAT_WIDTH  = 16;
   localparam int QUAT_FRAC   = QUAT_WIDTH - 2;

   // Quaternion products, rotation coefficients, point products, sums.
   localparam int SQ_WIDTH    = 2 * QUAT_WIDTH;
   localparam int COEF_WIDTH  = SQ_WIDTH + 2;
   localparam int PROD_WIDTH  = COEF_WIDTH + COORD_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 2;
   localparam int RSHIFT      = 2 * QUAT_FRAC;
   localparam int SHIFT_WIDTH = SUM_WIDTH - RSHIFT;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUAT_X = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUAT_Y = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUAT_Z = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUAT_W = 2'd3;

   // Cycles from a register write until the coefficient matrix is current.
   localparam int CFG_SETTLE       = 2;
   localparam int SETTLE_CNT_WIDTH = $clog2(CFG_SETTLE + 1);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [QUAT_WIDTH-1:0]  quat_type;
   typedef logic signed [SQ_WIDTH-1:0]    sq_type;
   typedef logic signed [COEF_WIDTH-1:0]  coef_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;
   typedef logic signed [SHIFT_WIDTH-1:0] shift_type;

   typedef coef_type coef_mat_type [3][3];
   typedef coord_type coord_vec_type [3];
   typedef sum_type sum_vec_type [3];

   localparam quat_type QUAT_ONE    = quat_type'(1) <<< QUAT_FRAC;
   localparam sum_type  ROUND_HALF  = sum_type'(1) <<< (RSHIFT - 1);
   localparam shift_type COORD_MAX  = (shift_type'(1) <<< (COORD_WIDTH - 1)) - shift_type'(1);
   localparam shift_type COORD_MIN  = -(shift_type'(1) <<< (COORD_WIDTH - 1));

   typedef struct packed {
      logic advance;   // every stage moves one place
      logic accept;    // an input beat enters the first stage
   } pipe_ctl_type;

endpackage

@@ rtl/qrv_coef.sv @@
// Quaternion registers and the two-stage pipeline that turns them into the
// 3x3 rotation matrix, plus the settle counter after a write. Uses qrv_pkg.
module qrv_coef (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [qrv_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [qrv_pkg::QUAT_WIDTH-1:0]         csr_wdata,
   output qrv_pkg::coef_mat_type                  coef,
   output logic                                   settling
);

   qrv_pkg::quat_type qx_ff, qy_ff, qz_ff, qw_ff;
   qrv_pkg::sq_type ww_ff, xx_ff, yy_ff, zz_ff, xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;
   qrv_pkg::coef_mat_type coef_ff, coef_in;
   logic [qrv_pkg::SETTLE_CNT_WIDTH-1:0] settle_ff, settle_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         qx_ff <= '0;
         qy_ff <= '0;
         qz_ff <= '0;
         qw_ff <= qrv_pkg::QUAT_ONE;
      end else if (csr_write) begin
         unique case (csr_index)
            qrv_pkg::REG_QUAT_X: qx_ff <= csr_wdata;
            qrv_pkg::REG_QUAT_Y: qy_ff <= csr_wdata;
            qrv_pkg::REG_QUAT_Z: qz_ff <= csr_wdata;
            qrv_pkg::REG_QUAT_W: qw_ff <= csr_wdata;
         endcase
      end
   end

   // Stage A: the ten pairwise products of the quaternion parts.
   always_ff @(posedge clock) begin
      ww_ff <= qrv_pkg::sq_type'(qw_ff) * qrv_pkg::sq_type'(qw_ff);
      xx_ff <= qrv_pkg::sq_type'(qx_ff) * qrv_pkg::sq_type'(qx_ff);
      yy_ff <= qrv_pkg::sq_type'(qy_ff) * qrv_pkg::sq_type'(qy_ff);
      zz_ff <= qrv_pkg::sq_type'(qz_ff) * qrv_pkg::sq_type'(qz_ff);
      xy_ff <= qrv_pkg::sq_type'(qx_ff) * qrv_pkg::sq_type'(qy_ff);
      wz_ff <= qrv_pkg::sq_type'(qw_ff) * qrv_pkg::sq_type'(qz_ff);
      xz_ff <= qrv_pkg::sq_type'(qx_ff) * qrv_pkg::sq_type'(qz_ff);
      wy_ff <= qrv_pkg::sq_type'(qw_ff) * qrv_pkg::sq_type'(qy_ff);
      yz_ff <= qrv_pkg::sq_type'(qy_ff) * qrv_pkg::sq_type'(qz_ff);
      wx_ff <= qrv_pkg::sq_type'(qw_ff) * qrv_pkg::sq_type'(qx_ff);
   end

   // Stage B: matrix of q * p * conj(q), exact, 28 fraction bits.
   always_comb begin
      coef_in[0][0] = qrv_pkg::coef_type'(ww_ff) + qrv_pkg::coef_type'(xx_ff)
                    - qrv_pkg::coef_type'(yy_ff) - qrv_pkg::coef_type'(zz_ff);
      coef_in[0][1] = (qrv_pkg::coef_type'(xy_ff) - qrv_pkg::coef_type'(wz_ff)) <<< 1;
      coef_in[0][2] = (qrv_pkg::coef_type'(xz_ff) + qrv_pkg::coef_type'(wy_ff)) <<< 1;
      coef_in[1][0] = (qrv_pkg::coef_type'(xy_ff) + qrv_pkg::coef_type'(wz_ff)) <<< 1;
      coef_in[1][1] = qrv_pkg::coef_type'(ww_ff) - qrv_pkg::coef_type'(xx_ff)
                    + qrv_pkg::coef_type'(yy_ff) - qrv_pkg::coef_type'(zz_ff);
      coef_in[1][2] = (qrv_pkg::coef_type'(yz_ff) - qrv_pkg::coef_type'(wx_ff)) <<< 1;
      coef_in[2][0] = (qrv_pkg::coef_type'(xz_ff) - qrv_pkg::coef_type'(wy_ff)) <<< 1;
      coef_in[2][1] = (qrv_pkg::coef_type'(yz_ff) + qrv_pkg::coef_type'(wx_ff)) <<< 1;
      coef_in[2][2] = qrv_pkg::coef_type'(ww_ff) - qrv_pkg::coef_type'(xx_ff)
                    - qrv_pkg::coef_type'(yy_ff) + qrv_pkg::coef_type'(zz_ff);
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
   end

   always_comb begin
      if (csr_write) begin
         settle_in = qrv_pkg::SETTLE_CNT_WIDTH'(qrv_pkg::CFG_SETTLE);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= qrv_pkg::SETTLE_CNT_WIDTH'(qrv_pkg::CFG_SETTLE);
      end else begin
         settle_ff <= settle_in;
      end
   end

   assign coef     = coef_ff;
   assign settling = (settle_ff != '0);

endmodule

@@ rtl/qrv_mac.sv @@
// Multiply-accumulate pipeline: point register, nine coefficient-by-point
// products, then the three row sums with the rounding offset. Uses qrv_pkg.
module qrv_mac (
   input  logic                     clock,
   input  logic                     reset,
   input  qrv_pkg::pipe_ctl_type    ctl,
   input  qrv_pkg::coord_vec_type   point,
   input  qrv_pkg::coef_mat_type    coef,
   output qrv_pkg::sum_vec_type     sum,
   output logic                     sum_valid
);

   qrv_pkg::coord_vec_type pt_ff;
   qrv_pkg::prod_type      prod_ff [3][3];
   qrv_pkg::prod_type      prod_in [3][3];
   qrv_pkg::sum_vec_type   sum_ff, sum_in;
   logic v1_ff, v2_ff, v3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = qrv_pkg::prod_type'(coef[i][j]) * qrv_pkg::prod_type'(pt_ff[j]);
         end
         sum_in[i] = qrv_pkg::sum_type'(prod_ff[i][0]) + qrv_pkg::sum_type'(prod_ff[i][1])
                   + qrv_pkg::sum_type'(prod_ff[i][2]) + qrv_pkg::ROUND_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (ctl.advance) begin
         v1_ff <= ctl.accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         pt_ff   <= point;
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
   end

   assign sum       = sum_ff;
   assign sum_valid = v3_ff;

   property p_stall_holds;
      @(posedge clock) disable iff (reset)
         !ctl.advance |=> $stable({v1_ff, v2_ff, v3_ff});
   endproperty
   a_stall_holds: assert property (p_stall_holds)
      else $error("pipeline valid bits moved during a stall");

endmodule

@@ rtl/qrv_sat.sv @@
// Output stage: drops the fraction bits, clamps each component to the
// coordinate range and holds the result beat. Uses qrv_pkg.
module qrv_sat (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     sum_valid,
   input  qrv_pkg::sum_vec_type     sum,
   output logic                     out_valid,
   output qrv_pkg::coord_vec_type   rotated,
   output logic                     saturated
);

   qrv_pkg::shift_type     scaled [3];
   qrv_pkg::coord_vec_type rot_in, rot_ff;
   logic [2:0] clip;
   logic valid_ff, sat_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         scaled[i] = qrv_pkg::shift_type'(sum[i] >>> qrv_pkg::RSHIFT);
         if (scaled[i] > qrv_pkg::COORD_MAX) begin
            clip[i]   = 1'b1;
            rot_in[i] = qrv_pkg::coord_type'(qrv_pkg::COORD_MAX);
         end else if (scaled[i] < qrv_pkg::COORD_MIN) begin
            clip[i]   = 1'b1;
            rot_in[i] = qrv_pkg::coord_type'(qrv_pkg::COORD_MIN);
         end else begin
            clip[i]   = 1'b0;
            rot_in[i] = qrv_pkg::coord_type'(scaled[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= sum_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && sum_valid) begin
         rot_ff <= rot_in;
         sat_ff <= |clip;
      end
   end

   assign out_valid = valid_ff;
   assign rotated   = rot_ff;
   assign saturated = sat_ff;

endmodule

@@ rtl/quaternion_rotate_vector.sv @@
// Top level of the quaternion point rotation block: register port, matrix
// pipeline, multiply-accumulate pipeline and output clamp stage. Uses qrv_pkg,
// qrv_coef, qrv_mac and qrv_sat.
//
//   channel  prefix  width of payload                   direction
//   input    req_    3 x 24-bit signed point            in
//   result   rsp_    3 x 24-bit signed point + 1 flag   out
//   config   csr_    2-bit index, 16-bit data           in
//
// One point is taken per clock while req_ready is high; each input beat then
// passes the point register, products, row sums and clamp register.
// The whole item pipeline moves together and freezes while a result waits.
// After reset and after each register write, req_ready stays low while the
// rotation matrix pipeline refills. csr_ready is always high.
module quaternion_rotate_vector (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [qrv_pkg::COORD_WIDTH-1:0]        req_point_x,
   input  logic [qrv_pkg::COORD_WIDTH-1:0]        req_point_y,
   input  logic [qrv_pkg::COORD_WIDTH-1:0]        req_point_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [qrv_pkg::COORD_WIDTH-1:0]        rsp_rotated_x,
   output logic [qrv_pkg::COORD_WIDTH-1:0]        rsp_rotated_y,
   output logic [qrv_pkg::COORD_WIDTH-1:0]        rsp_rotated_z,
   output logic                                   rsp_saturated,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [qrv_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [qrv_pkg::QUAT_WIDTH-1:0]         csr_wdata
);

   qrv_pkg::coef_mat_type  coef;
   qrv_pkg::coord_vec_type point, rotated;
   qrv_pkg::sum_vec_type   sum;
   qrv_pkg::pipe_ctl_type  ctl;
   logic settling, sum_valid, out_valid;

   assign csr_ready   = 1'b1;
   assign ctl.advance = !out_valid || rsp_ready;
   assign req_ready   = ctl.advance && !settling;
   assign ctl.accept  = req_valid && req_ready;

   assign point[0] = req_point_x;
   assign point[1] = req_point_y;
   assign point[2] = req_point_z;

   qrv_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef),
      .settling  (settling)
   );

   qrv_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .point     (point),
      .coef      (coef),
      .sum       (sum),
      .sum_valid (sum_valid)
   );

   qrv_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .advance   (ctl.advance),
      .sum_valid (sum_valid),
      .sum       (sum),
      .out_valid (out_valid),
      .rotated   (rotated),
      .saturated (rsp_saturated)
   );

   assign rsp_valid     = out_valid;
   assign rsp_rotated_x = rotated[0];
   assign rsp_rotated_y = rotated[1];
   assign rsp_rotated_z = rotated[2];

   // A point must not see a half-updated rotation matrix.
   property p_write_blocks_input;
      @(posedge clock) disable iff (reset)
         (csr_valid && csr_ready) |=> !req_ready ##1 !req_ready;
   endproperty
   a_write_blocks_input: assert property (p_write_blocks_input)
      else $error("input beat taken before the rotation matrix settled");

   property p_reset_blocks_input;
      @(posedge clock) disable iff (reset)
         $fell(reset) |-> !req_ready;
   endproperty
   a_reset_blocks_input: assert property (p_reset_blocks_input)
      else $error("input beat taken right after reset");

   property p_stalled_output_blocks_input;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_ready) |-> !req_ready;
   endproperty
   a_stalled_output_blocks_input: assert property (p_stalled_output_blocks_input)
      else $error("input beat taken while the pipeline is frozen");

endmodule
